// ===== hdl/owbm_pkg.sv =====
// Shared types, register indexes, reset values and helpers for the single-wire bus master.
package owbm_pkg;

	// Default recovery release after a write-zero slot, in ticks.
	localparam int unsigned RECOVERY_TICKS_DEF = 1;

	localparam int unsigned CFG_W      = 10;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned LEN_W      = CFG_W + 1;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WR1_LOW       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WR1_REST      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WR0_LOW       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_REST     = 3'd7;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
	localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd80;
	localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd400;
	localparam logic [CFG_W-1:0] RST_WR1_LOW       = 10'd1;
	localparam logic [CFG_W-1:0] RST_WR1_REST      = 10'd50;
	localparam logic [CFG_W-1:0] RST_WR0_LOW       = 10'd50;
	localparam logic [CFG_W-1:0] RST_READ_LOW      = 10'd2;
	localparam logic [CFG_W-1:0] RST_READ_REST     = 10'd60;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_RST_LOW   = 6'b000010,
		PH_RST_WAIT  = 6'b000100,
		PH_RST_TAIL  = 6'b001000,
		PH_SLOT_LOW  = 6'b010000,
		PH_SLOT_REST = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low_ticks;
		logic [CFG_W-1:0] presence_wait_ticks;
		logic [CFG_W-1:0] reset_tail_ticks;
		logic [CFG_W-1:0] write_one_low_ticks;
		logic [CFG_W-1:0] write_one_rest_ticks;
		logic [CFG_W-1:0] write_zero_low_ticks;
		logic [CFG_W-1:0] read_low_ticks;
		logic [CFG_W-1:0] read_rest_ticks;
	} cfg_t;

	typedef struct packed {
		op_t              command;
		logic [BYTE_W-1:0] write_data;
		logic             line_level;
	} item_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic              presence;
		logic [BYTE_W-1:0] read_byte;
	} result_t;

	// A low pulse or wait programmed as zero lasts one tick.
	function automatic logic [LEN_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = (v == '0) ? LEN_W'(1) : {1'b0, v};
		return r;
	endfunction

endpackage

// ===== hdl/owbm_cfg_regs.sv =====
// Timing register file of the single-wire bus master.
module owbm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [owbm_pkg::CFG_W-1:0]      cfg_wdata,
	output owbm_pkg::cfg_t                  cfg
);

	owbm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks      <= owbm_pkg::RST_RESET_LOW;
			cfg_q.presence_wait_ticks  <= owbm_pkg::RST_PRESENCE_WAIT;
			cfg_q.reset_tail_ticks     <= owbm_pkg::RST_RESET_TAIL;
			cfg_q.write_one_low_ticks  <= owbm_pkg::RST_WR1_LOW;
			cfg_q.write_one_rest_ticks <= owbm_pkg::RST_WR1_REST;
			cfg_q.write_zero_low_ticks <= owbm_pkg::RST_WR0_LOW;
			cfg_q.read_low_ticks       <= owbm_pkg::RST_READ_LOW;
			cfg_q.read_rest_ticks      <= owbm_pkg::RST_READ_REST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				owbm_pkg::REG_RESET_LOW:     cfg_q.reset_low_ticks      <= cfg_wdata;
				owbm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait_ticks  <= cfg_wdata;
				owbm_pkg::REG_RESET_TAIL:    cfg_q.reset_tail_ticks     <= cfg_wdata;
				owbm_pkg::REG_WR1_LOW:       cfg_q.write_one_low_ticks  <= cfg_wdata;
				owbm_pkg::REG_WR1_REST:      cfg_q.write_one_rest_ticks <= cfg_wdata;
				owbm_pkg::REG_WR0_LOW:       cfg_q.write_zero_low_ticks <= cfg_wdata;
				owbm_pkg::REG_READ_LOW:      cfg_q.read_low_ticks       <= cfg_wdata;
				owbm_pkg::REG_READ_REST:     cfg_q.read_rest_ticks      <= cfg_wdata;
				default:                     cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/owbm_seq.sv =====
// Slot sequencer: advances the bus state by one tick per step and forms that tick's result.
module owbm_seq #(
	parameter int unsigned RECOVERY_TICKS = owbm_pkg::RECOVERY_TICKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  owbm_pkg::item_t   item,
	input  owbm_pkg::cfg_t    cfg,
	output owbm_pkg::result_t result
);

	localparam int unsigned LW = owbm_pkg::LEN_W;
	localparam int unsigned CW = owbm_pkg::CFG_W;
	localparam int unsigned BW = owbm_pkg::BYTE_W;

	owbm_pkg::phase_t ph_q, ph_e, ph_d;
	owbm_pkg::op_t    op_q, op_e;
	logic [CW-1:0]    tc_q, tc_e, tc_d;
	logic [2:0]       bi_q, bi_e, bi_d;
	logic [BW-1:0]    sb_q, sb_e, sb_d;
	logic             pres_q, pres_d;
	logic [BW-1:0]    last_q, last_d;

	logic             start;
	logic             cur_bit;
	logic [LW-1:0]    rest_len;
	logic [LW-1:0]    len;
	logic [LW-1:0]    next_tc;
	logic             seg_end;
	logic             drive, busy, done;

	always_comb begin
		// A command in idle makes this tick the first tick of the operation.
		start = (ph_q == owbm_pkg::PH_IDLE) && (item.command != owbm_pkg::OP_NONE);
		op_e  = start ? item.command : op_q;
		tc_e  = start ? '0 : tc_q;
		bi_e  = start ? '0 : bi_q;
		if (start) begin
			sb_e = (item.command == owbm_pkg::OP_WRITE) ? item.write_data : '0;
			ph_e = (item.command == owbm_pkg::OP_RESET) ? owbm_pkg::PH_RST_LOW
			                                            : owbm_pkg::PH_SLOT_LOW;
		end else begin
			sb_e = sb_q;
			ph_e = ph_q;
		end

		cur_bit = sb_e[bi_e];
		if (op_e == owbm_pkg::OP_WRITE) begin
			rest_len = cur_bit ? {1'b0, cfg.write_one_rest_ticks} : LW'(RECOVERY_TICKS);
		end else begin
			rest_len = {1'b0, cfg.read_rest_ticks} + LW'(1);
		end

		unique case (ph_e)
			owbm_pkg::PH_RST_LOW:  len = owbm_pkg::at_least_one(cfg.reset_low_ticks);
			owbm_pkg::PH_RST_WAIT: len = owbm_pkg::at_least_one(cfg.presence_wait_ticks);
			owbm_pkg::PH_RST_TAIL: len = {1'b0, cfg.reset_tail_ticks};
			owbm_pkg::PH_SLOT_LOW: begin
				if (op_e == owbm_pkg::OP_WRITE) begin
					len = owbm_pkg::at_least_one(cur_bit ? cfg.write_one_low_ticks
					                                     : cfg.write_zero_low_ticks);
				end else begin
					len = owbm_pkg::at_least_one(cfg.read_low_ticks);
				end
			end
			owbm_pkg::PH_SLOT_REST: len = rest_len;
			default:                len = LW'(1);
		endcase

		next_tc = {1'b0, tc_e} + LW'(1);
		seg_end = (next_tc >= len);

		ph_d   = ph_e;
		tc_d   = tc_e;
		bi_d   = bi_e;
		sb_d   = sb_e;
		pres_d = pres_q;
		last_d = last_q;
		drive  = 1'b0;
		busy   = 1'b0;
		done   = 1'b0;

		if (ph_e != owbm_pkg::PH_IDLE) begin
			busy  = 1'b1;
			drive = (ph_e == owbm_pkg::PH_RST_LOW) || (ph_e == owbm_pkg::PH_SLOT_LOW);

			// Presence is sampled on the last released wait tick.
			if ((ph_e == owbm_pkg::PH_RST_WAIT) && seg_end) begin
				pres_d = ~item.line_level;
			end
			// A read slot samples the line on its first released tick.
			if ((ph_e == owbm_pkg::PH_SLOT_REST) && (op_e != owbm_pkg::OP_WRITE) &&
			    (tc_e == '0) && item.line_level) begin
				sb_d[bi_e] = 1'b1;
			end

			if (!seg_end) begin
				tc_d = next_tc[CW-1:0];
			end else begin
				tc_d = '0;
				unique case (ph_e)
					owbm_pkg::PH_RST_LOW: ph_d = owbm_pkg::PH_RST_WAIT;
					owbm_pkg::PH_RST_WAIT: begin
						// An empty tail ends the reset on the sample tick.
						if (cfg.reset_tail_ticks == '0) begin
							ph_d = owbm_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							ph_d = owbm_pkg::PH_RST_TAIL;
						end
					end
					owbm_pkg::PH_SLOT_LOW: begin
						// An empty rest ends the slot on its last low tick.
						if (rest_len != '0) begin
							ph_d = owbm_pkg::PH_SLOT_REST;
						end else if (bi_e == 3'd7) begin
							ph_d = owbm_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							bi_d = bi_e + 3'd1;
							ph_d = owbm_pkg::PH_SLOT_LOW;
						end
					end
					owbm_pkg::PH_SLOT_REST: begin
						if (bi_e == 3'd7) begin
							ph_d = owbm_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							bi_d = bi_e + 3'd1;
							ph_d = owbm_pkg::PH_SLOT_LOW;
						end
					end
					default: begin
						ph_d = owbm_pkg::PH_IDLE;
						done = 1'b1;
					end
				endcase
				if (done && (op_e == owbm_pkg::OP_READ)) begin
					last_d = sb_d;
				end
			end
		end

		result.drive_low = drive;
		result.busy_res  = busy;
		result.done_res  = done;
		result.presence  = pres_d;
		result.read_byte = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= owbm_pkg::PH_IDLE;
			op_q   <= owbm_pkg::OP_NONE;
			tc_q   <= '0;
			bi_q   <= '0;
			sb_q   <= '0;
			pres_q <= 1'b0;
			last_q <= '0;
		end else if (step) begin
			ph_q   <= ph_d;
			op_q   <= op_e;
			tc_q   <= tc_d;
			bi_q   <= bi_d;
			sb_q   <= sb_d;
			pres_q <= pres_d;
			last_q <= last_d;
		end
	end

endmodule

// ===== hdl/one_wire_bus_master_unit.sv =====
// Top level of the single-wire bus master: tick stream in, per-tick bus result out.
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------------
// s_*       | s_tvalid / s_tready        | one tick: command, write byte, line level
// m_*       | m_tvalid / m_tready        | one result per tick: drive, busy, done, ...
// cfg_*     | cfg_wr_en (no wait)        | timing register index and value
//
// Every input transaction is one bus tick and produces exactly one output transaction.
// A tick is held in the input register, where the sequencer evaluates it, and its result
// is registered in the output register; one tick per cycle is sustained without stalls.
// The input register advances whenever the output register is empty or is being taken,
// so a stall on the master side holds both registers and the bus state in place.
// Reset returns the sequencer to idle and loads the timing registers with their defaults.
module one_wire_bus_master_unit #(
	parameter int unsigned RECOVERY_TICKS = owbm_pkg::RECOVERY_TICKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] command, [9:2] write_data, [10] line_level, [15:11] zero
	input  logic [owbm_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_byte,
	// [15:12] zero
	output logic [owbm_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                              cfg_wr_en,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [owbm_pkg::CFG_W-1:0]        cfg_wdata
);

	owbm_pkg::cfg_t    cfg;
	owbm_pkg::item_t   item_s1;
	logic              valid_s1;
	owbm_pkg::result_t seq_result;
	owbm_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;
	logic              step;

	// The output register can take a new result when it is empty or draining.
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// The payload register needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.command    <= owbm_pkg::op_t'(s_tdata[1:0]);
			item_s1.write_data <= s_tdata[9:2];
			item_s1.line_level <= s_tdata[10];
		end
	end

	owbm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	owbm_seq #(
		.RECOVERY_TICKS (RECOVERY_TICKS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (seq_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= seq_result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, result_s2.read_byte, result_s2.presence,
	                   result_s2.done_res, result_s2.busy_res, result_s2.drive_low};

`ifndef ASSERT_OFF
	// A completed operation is always reported as busy on its last tick.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (!result_s2.done_res || result_s2.busy_res))
		else $error("done reported without busy");

	// The line is only driven while an operation is in progress.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (!result_s2.drive_low || result_s2.busy_res))
		else $error("line driven while idle");

	// A tick held in the input register by a stall keeps its contents.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> $stable(item_s1))
		else $error("stalled tick changed in input register");
`endif

endmodule

// ===== tb/owbm_tb_pkg.sv =====
// Scoreboard for the single-wire bus master testbench: per-tick bus predictor and result check.
package owbm_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import owbm_pkg::*;

	class bus_tick_scoreboard;
		cfg_t        timing;
		phase_t      phase;
		op_t         oper;
		int unsigned tick_count;
		logic [2:0]  bit_idx;
		logic [7:0]  shift_reg;
		logic        presence_flag;
		logic [7:0]  last_read;
		result_t     bus_results_q[$];
		int unsigned errors;
		int unsigned ticks;
		int unsigned resets_run;
		int unsigned writes_run;
		int unsigned reads_run;
		int unsigned completions;
		int unsigned presence_high;
		int unsigned presence_low;

		function new();
			timing.reset_low_ticks     = RST_RESET_LOW;
			timing.presence_wait_ticks = RST_PRESENCE_WAIT;
			timing.reset_tail_ticks    = RST_RESET_TAIL;
			timing.write_one_low_ticks = RST_WR1_LOW;
			timing.write_one_rest_ticks = RST_WR1_REST;
			timing.write_zero_low_ticks = RST_WR0_LOW;
			timing.read_low_ticks      = RST_READ_LOW;
			timing.read_rest_ticks     = RST_READ_REST;
			phase         = PH_IDLE;
			oper          = OP_NONE;
			tick_count    = 0;
			bit_idx       = '0;
			shift_reg     = '0;
			presence_flag = 1'b0;
			last_read     = '0;
			errors        = 0;
			ticks         = 0;
			resets_run    = 0;
			writes_run    = 0;
			reads_run     = 0;
			completions   = 0;
			presence_high = 0;
			presence_low  = 0;
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction

		function int unsigned pending();
			return bus_results_q.size();
		endfunction

		// Low pulses and the presence wait never last less than one tick.
		function int unsigned min_one(logic [CFG_W-1:0] v);
			return (v == '0) ? 1 : v;
		endfunction

		// Length in ticks of the segment the sequencer is in; zero means it is skipped.
		function int unsigned segment_ticks(phase_t ph);
			case (ph)
				PH_RST_LOW:  return min_one(timing.reset_low_ticks);
				PH_RST_WAIT: return min_one(timing.presence_wait_ticks);
				PH_RST_TAIL: return timing.reset_tail_ticks;
				PH_SLOT_LOW: begin
					if (oper == OP_WRITE)
						return min_one(shift_reg[bit_idx] ? timing.write_one_low_ticks
							: timing.write_zero_low_ticks);
					return min_one(timing.read_low_ticks);
				end
				PH_SLOT_REST: begin
					if (oper == OP_WRITE)
						return shift_reg[bit_idx] ? timing.write_one_rest_ticks
							: RECOVERY_TICKS_DEF;
					return timing.read_rest_ticks + 1;
				end
				default: return 1;
			endcase
		endfunction

		// Advances the bus sequencer by one accepted tick and queues the result it must give.
		function void note_tick(item_t it);
			int unsigned span;
			int unsigned nxt;
			bit          moving;
			result_t     r;
			r = '0;
			ticks++;
			if (phase == PH_IDLE && it.command != OP_NONE) begin
				oper       = it.command;
				tick_count = 0;
				bit_idx    = '0;
				shift_reg  = (it.command == OP_WRITE) ? it.write_data : '0;
				phase      = (it.command == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
				case (it.command)
					OP_RESET: resets_run++;
					OP_WRITE: writes_run++;
					default:  reads_run++;
				endcase
			end
			if (phase != PH_IDLE) begin
				span = segment_ticks(phase);
				nxt  = tick_count + 1;
				r.busy_res  = 1'b1;
				r.drive_low = (phase == PH_RST_LOW || phase == PH_SLOT_LOW);
				if (phase == PH_RST_WAIT && nxt >= span) begin
					presence_flag = !it.line_level;
					if (it.line_level)
						presence_low++;
					else
						presence_high++;
				end
				// A read slot samples the line on its first released tick.
				if (phase == PH_SLOT_REST && oper != OP_WRITE && tick_count == 0 && it.line_level)
					shift_reg[bit_idx] = 1'b1;
				if (nxt < span) begin
					tick_count = nxt;
				end else begin
					tick_count = 0;
					moving     = 1'b1;
					while (moving) begin
						moving = 1'b0;
						case (phase)
							PH_RST_LOW: phase = PH_RST_WAIT;
							PH_RST_WAIT: begin
								phase = PH_RST_TAIL;
								moving = (segment_ticks(PH_RST_TAIL) == 0);
							end
							PH_SLOT_LOW: begin
								phase = PH_SLOT_REST;
								moving = (segment_ticks(PH_SLOT_REST) == 0);
							end
							PH_SLOT_REST: begin
								if (bit_idx == 3'd7) begin
									phase      = PH_IDLE;
									r.done_res = 1'b1;
								end else begin
									bit_idx = bit_idx + 1'b1;
									phase   = PH_SLOT_LOW;
								end
							end
							default: begin
								phase      = PH_IDLE;
								r.done_res = 1'b1;
							end
						endcase
					end
					if (r.done_res) begin
						completions++;
						if (oper == OP_READ)
							last_read = shift_reg;
					end
				end
			end
			r.presence  = presence_flag;
			r.read_byte = last_read;
			bus_results_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// Compares one output transaction with the oldest outstanding expectation.
		function void check_result(logic [OUT_TDATA_W-1:0] td);
			result_t want;
			if (bus_results_q.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived, expected none, actual %h", $time, td, td);
				return;
			end
			want = bus_results_q.pop_front();
			compare_field("drive_low", want.drive_low, td[0]);
			compare_field("busy_res", want.busy_res, td[1]);
			compare_field("done_res", want.done_res, td[2]);
			compare_field("presence", want.presence, td[3]);
			compare_field("read_byte", want.read_byte, td[11:4]);
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench of the single-wire bus master: stimulus, handshakes and final verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import owbm_pkg::*;
	import owbm_tb_pkg::*;

	// How the sampled line level is chosen for each tick of an operation.
	typedef enum {LINE_RANDOM, LINE_HIGH, LINE_LOW} line_mode_t;

	// Tick budget of the run, and the point after which nobody idles.
	localparam int unsigned TICK_BUDGET = 800;
	localparam int unsigned IDLE_UNTIL  = 700;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [1:0] command, [9:2] write_data, [10] line_level, [15:11] zero
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_byte, [15:12] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;

	bus_tick_scoreboard sb;
	bit                 idling = 1'b1;
	int unsigned        stall_left = 0;
	int unsigned        timing_loads = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	one_wire_bus_master_unit #(
		.RECOVERY_TICKS(RECOVERY_TICKS_DEF)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// The receiver stalls in bursts of random length while idling is enabled, so that
	// back-pressure lands on every phase of the sequencer's work.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every output transaction is checked against the oldest predicted tick result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic logic pick_line(line_mode_t mode);
		case (mode)
			LINE_HIGH: return 1'b1;
			LINE_LOW:  return 1'b0;
			default:   return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Presents one tick and holds it until the block takes it. The valid stays high from one
	// transaction to the next unless a random sender gap is inserted first.
	task automatic send_tick(input op_t cmd, input logic [7:0] wd, input logic line);
		item_t it;
		it.command    = cmd;
		it.write_data = wd;
		it.line_level = line;
		@(negedge clk);
		if (idling && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, line, wd, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(it);
	endtask

	// One ordinary tick. While an operation runs, now and then a command is slipped in that
	// the sequencer must ignore.
	task automatic bus_tick(input line_mode_t mode);
		op_t cmd;
		cmd = OP_NONE;
		if (sb.busy() && $urandom_range(0, 5) == 0)
			cmd = op_t'($urandom_range(0, 3));
		send_tick(cmd, 8'($urandom_range(0, 255)), pick_line(mode));
	endtask

	// Starts one operation on an idle sequencer and runs it to completion, followed by zero
	// to two plain ticks, so operations also come back to back.
	task automatic run_op(input op_t op, input logic [7:0] wd, input line_mode_t mode);
		while (sb.busy())
			bus_tick(mode);
		send_tick(op, wd, pick_line(mode));
		while (sb.busy())
			bus_tick(mode);
		repeat ($urandom_range(0, 2)) bus_tick(mode);
	endtask

	// Brings the sequencer to idle, stops sending and waits for every outstanding result,
	// then waits for the pipeline registers to drain.
	task automatic settle();
		while (sb.busy())
			bus_tick(LINE_RANDOM);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
	endtask

	// Writes all eight timing registers; only called while the block is idle and drained.
	task automatic load_timing(input cfg_t c);
		write_reg(REG_RESET_LOW, c.reset_low_ticks);
		write_reg(REG_PRESENCE_WAIT, c.presence_wait_ticks);
		write_reg(REG_RESET_TAIL, c.reset_tail_ticks);
		write_reg(REG_WR1_LOW, c.write_one_low_ticks);
		write_reg(REG_WR1_REST, c.write_one_rest_ticks);
		write_reg(REG_WR0_LOW, c.write_zero_low_ticks);
		write_reg(REG_READ_LOW, c.read_low_ticks);
		write_reg(REG_READ_REST, c.read_rest_ticks);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.timing = c;
		timing_loads++;
	endtask

	// Mostly very short segments so that many operations fit in the run; zero shows up
	// often to exercise skipped rests and minimum low pulses.
	function automatic cfg_t random_timing();
		cfg_t c;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 15))
				0:       c[i*CFG_W +: CFG_W] = '0;
				1:       c[i*CFG_W +: CFG_W] = CFG_W'($urandom_range(5, 20));
				default: c[i*CFG_W +: CFG_W] = CFG_W'($urandom_range(1, 4));
			endcase
		end
		return c;
	endfunction

	initial begin
		cfg_t        mixed;
		int unsigned n_ops;
		line_mode_t  mode;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default timing: one byte write, which covers the write slots and the recovery release.
		run_op(OP_WRITE, 8'hA5, LINE_RANDOM);

		// All registers zero: low pulses fall back to one tick, the write-one rest and the tail vanish.
		settle();
		load_timing({8{10'd0}});
		run_op(OP_RESET, 8'h00, LINE_HIGH);
		run_op(OP_WRITE, 8'h00, LINE_RANDOM);
		run_op(OP_WRITE, 8'hFF, LINE_RANDOM);
		run_op(OP_READ, 8'h00, LINE_HIGH);
		run_op(OP_READ, 8'h00, LINE_LOW);
		run_op(OP_RESET, 8'h00, LINE_LOW);

		// One-tick pulses with a skipped write-one rest and tail, but a longer presence wait.
		settle();
		mixed = {8{10'd1}};
		mixed.presence_wait_ticks  = 10'd30;
		mixed.reset_tail_ticks     = 10'd0;
		mixed.write_one_rest_ticks = 10'd0;
		mixed.read_rest_ticks      = 10'd0;
		load_timing(mixed);
		run_op(OP_RESET, 8'h00, LINE_LOW);
		run_op(OP_WRITE, 8'h96, LINE_RANDOM);
		run_op(OP_READ, 8'h00, LINE_RANDOM);
		run_op(OP_READ, 8'h00, LINE_RANDOM);

		// Random phases: new timing, then a handful of operations with random content.
		// The final stretch runs with no gaps on either side.
		while (sb.ticks < TICK_BUDGET) begin
			settle();
			load_timing(random_timing());
			idling = (sb.ticks < IDLE_UNTIL) && ($urandom_range(0, 3) != 0);
			n_ops = $urandom_range(2, 5);
			for (int k = 0; k < n_ops; k++) begin
				mode = ($urandom_range(0, 3) == 0) ? line_mode_t'($urandom_range(1, 2))
					: LINE_RANDOM;
				run_op(op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), mode);
				if (sb.ticks >= TICK_BUDGET || (idling && sb.ticks >= IDLE_UNTIL))
					break;
				// Occasionally hold the sender until the output side has fully caught up.
				if ($urandom_range(0, 9) == 0)
					settle();
			end
		end

		settle();
		$display("Ran %0d ticks: %0d bus resets, %0d byte writes, %0d byte reads, %0d completed.",
			sb.ticks, sb.resets_run, sb.writes_run, sb.reads_run, sb.completions);
		$display("Presence found %0d times and missed %0d times over %0d timing settings.",
			sb.presence_high, sb.presence_low, timing_loads + 1);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run, stalls and gaps included.
	initial begin
		#(2_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/owbm_pkg.sv
hdl/owbm_cfg_regs.sv
hdl/owbm_seq.sv
hdl/one_wire_bus_master_unit.sv
tb/owbm_tb_pkg.sv
tb/tb_top.sv
